[rtl/rru_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rru_pkg
// Types, widths and helper functions shared by the ray refraction unit.
// ----------------------------------------------------------------------------
package rru_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int CW              = COMPONENT_WIDTH;
    localparam int DW              = 16;    // internal direction/normal width
    localparam int EW              = 16;    // refractive index width, Q4.12
    localparam int C16_MAX         = 32767;
    localparam int C16_MIN         = -32768;

    // square root pipeline: 60-bit radicand, 30-bit root, two bits per stage
    localparam int SQ_IN_W   = 60;
    localparam int SQ_OUT_W  = 30;
    localparam int SQ_REM_W  = SQ_OUT_W + 1;
    localparam int SQ_STEPS  = 2;
    localparam int SQ_STAGES = SQ_OUT_W / SQ_STEPS;

    // normalizing divider: 15 quotient bits, three per stage
    localparam int Q_W        = 15;
    localparam int NUM_W      = DW + 28;
    localparam int DR_W       = SQ_OUT_W;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = Q_W / DIV_STEPS;

    // datapath widths
    localparam int SS_W  = 2 * DW;          // one squared magnitude / sum of squares
    localparam int PR1_W = 2 * DW;          // nv * n
    localparam int DOT_W = PR1_W + 2;
    localparam int D_W   = DOT_W - 14 + 1;  // rounded dot product, signed
    localparam int DD_W  = 2 * D_W;
    localparam int E2_W  = 2 * EW - 8;
    localparam int DN_W  = D_W + DW;
    localparam int OM_W  = DD_W + 1;
    localparam int PR_W  = E2_W + 1 + OM_W;
    localparam int T_W   = DN_W + 1;
    localparam int M1_W  = EW + 1 + T_W;
    localparam int M2_W  = SQ_OUT_W + 1 + DW;
    localparam int R_W   = M1_W + 1;
    localparam int O_W   = 34;

    // eta^2 * (1 - d^2) is formed from two partial products on a split of om
    localparam int OML_W = 21;
    localparam int OMH_W = OM_W - OML_W;
    localparam int PL_W  = E2_W + OML_W;
    localparam int PH_W  = E2_W + 1 + OMH_W;

    typedef logic signed [DW-1:0] t_comp;
    typedef t_comp [2:0]          t_vec;

    typedef struct packed {
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
        logic signed [CW-1:0] norm_x;
        logic signed [CW-1:0] norm_y;
        logic signed [CW-1:0] norm_z;
        logic [EW-1:0]        eta_ratio;
    } t_ray_in;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic                 refracts;
    } t_ray_out;

    // sideband carried through the length square root
    typedef struct packed {
        logic          zero;
        t_vec          dv;
        t_vec          nn;
        logic [EW-1:0] eta;
    } t_side_len;

    // sideband carried through the divider
    typedef struct packed {
        logic          zero;
        logic [2:0]    sgn;
        t_vec          nn;
        logic [EW-1:0] eta;
    } t_side_div;

    // sideband carried through the discriminant square root
    typedef struct packed {
        logic                        pos;
        logic signed [2:0][T_W-1:0]  t;
        t_vec                        nn;
        logic [EW-1:0]               eta;
    } t_side_sq;

    localparam int SIDE_W = 184;
    typedef logic [SIDE_W-1:0] t_side;

    // clamp a port component to the signed 16-bit datapath range
    function automatic t_comp clamp_comp(input logic signed [CW-1:0] v);
        logic signed [CW+DW-1:0] w;
        w = (CW+DW)'(v);
        if (w > (CW+DW)'(C16_MAX)) begin
            w = (CW+DW)'(C16_MAX);
        end else if (w < (CW+DW)'(C16_MIN)) begin
            w = (CW+DW)'(C16_MIN);
        end
        return DW'(w);
    endfunction

    function automatic logic [DW-1:0] mag_comp(input t_comp v);
        return v[DW-1] ? DW'(~v + 1'b1) : DW'(v);
    endfunction

endpackage

[rtl/rru_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rru_in_if
// Ray input channel: valid/ready with the incident ray as payload.
// ----------------------------------------------------------------------------
interface rru_in_if;
    import rru_pkg::*;

    logic    valid;
    logic    ready;
    t_ray_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/rru_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rru_out_if
// Result channel: valid/ready with the refracted direction as payload.
// ----------------------------------------------------------------------------
interface rru_out_if;
    import rru_pkg::*;

    logic     valid;
    logic     ready;
    t_ray_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/rru_sqrt_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rru_sqrt_pipe
// Pipelined floor square root, two root bits per stage, with sideband.
// ----------------------------------------------------------------------------
module rru_sqrt_pipe (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [rru_pkg::SQ_IN_W-1:0]  i_radicand,
    input  rru_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [rru_pkg::SQ_OUT_W-1:0] o_root,
    output rru_pkg::t_side               o_side
);
    import rru_pkg::*;

    logic [SQ_STAGES-1:0] r_vld;
    logic [SQ_IN_W-1:0]   r_x    [SQ_STAGES];
    logic [SQ_REM_W-1:0]  r_rem  [SQ_STAGES];
    logic [SQ_OUT_W-1:0]  r_root [SQ_STAGES];
    t_side                r_side [SQ_STAGES];

    logic [SQ_IN_W-1:0]   p_x    [SQ_STAGES];
    logic [SQ_REM_W-1:0]  p_rem  [SQ_STAGES];
    logic [SQ_OUT_W-1:0]  p_root [SQ_STAGES];
    t_side                p_side [SQ_STAGES];

    logic [SQ_IN_W-1:0]   n_x    [SQ_STAGES];
    logic [SQ_REM_W-1:0]  n_rem  [SQ_STAGES];
    logic [SQ_OUT_W-1:0]  n_root [SQ_STAGES];

    always_comb begin
        p_x[0]    = i_radicand;
        p_rem[0]  = '0;
        p_root[0] = '0;
        p_side[0] = i_side;
        for (int s = 1; s < SQ_STAGES; s++) begin
            p_x[s]    = r_x[s-1];
            p_rem[s]  = r_rem[s-1];
            p_root[s] = r_root[s-1];
            p_side[s] = r_side[s-1];
        end
    end

    always_comb begin
        logic [SQ_IN_W-1:0]  x;
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_OUT_W-1:0] root;
        logic [SQ_REM_W+1:0] sh;
        logic [SQ_REM_W:0]   trial;
        for (int s = 0; s < SQ_STAGES; s++) begin
            x    = p_x[s];
            rem  = p_rem[s];
            root = p_root[s];
            for (int k = 0; k < SQ_STEPS; k++) begin
                sh    = {rem, x[SQ_IN_W-1 -: 2]};
                trial = {root, 2'b01};
                x     = {x[SQ_IN_W-3:0], 2'b00};
                if (sh >= {1'b0, trial}) begin
                    rem  = SQ_REM_W'(sh - {1'b0, trial});
                    root = {root[SQ_OUT_W-2:0], 1'b1};
                end else begin
                    rem  = SQ_REM_W'(sh);
                    root = {root[SQ_OUT_W-2:0], 1'b0};
                end
            end
            n_x[s]    = x;
            n_rem[s]  = rem;
            n_root[s] = root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQ_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < SQ_STAGES; s++) begin
                r_x[s]    <= n_x[s];
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_side[s] <= p_side[s];
            end
        end
    end

    assign o_valid = r_vld[SQ_STAGES-1];
    assign o_root  = r_root[SQ_STAGES-1];
    assign o_side  = r_side[SQ_STAGES-1];

endmodule

[rtl/rru_div_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rru_div_pipe
// Three-lane pipelined divider: round(mag * 2^28 / len), three bits per stage.
// ----------------------------------------------------------------------------
module rru_div_pipe (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [rru_pkg::SQ_OUT_W-1:0]      i_len,
    input  logic [2:0][rru_pkg::DW-1:0]       i_mag,
    input  rru_pkg::t_side                    i_side,
    output logic                              o_valid,
    output logic [2:0][rru_pkg::Q_W-1:0]      o_quot,
    output rru_pkg::t_side                    o_side
);
    import rru_pkg::*;

    logic [DIV_STAGES-1:0]    r_vld;
    logic [SQ_OUT_W-1:0]      r_len  [DIV_STAGES];
    logic [2:0][DR_W-1:0]     r_rem  [DIV_STAGES];
    logic [2:0][Q_W-1:0]      r_lo   [DIV_STAGES];
    logic [2:0][Q_W-1:0]      r_q    [DIV_STAGES];
    t_side                    r_side [DIV_STAGES];

    logic [SQ_OUT_W-1:0]      p_len  [DIV_STAGES];
    logic [2:0][DR_W-1:0]     p_rem  [DIV_STAGES];
    logic [2:0][Q_W-1:0]      p_lo   [DIV_STAGES];
    logic [2:0][Q_W-1:0]      p_q    [DIV_STAGES];
    t_side                    p_side [DIV_STAGES];

    logic [2:0][DR_W-1:0]     n_rem  [DIV_STAGES];
    logic [2:0][Q_W-1:0]      n_lo   [DIV_STAGES];
    logic [2:0][Q_W-1:0]      n_q    [DIV_STAGES];

    always_comb begin
        logic [NUM_W-1:0] num;
        for (int l = 0; l < 3; l++) begin
            // bias by half the divisor so the quotient rounds to nearest
            num         = {i_mag[l], 28'd0} + NUM_W'(i_len >> 1);
            p_rem[0][l] = DR_W'(num[NUM_W-1:Q_W]);
            p_lo[0][l]  = num[Q_W-1:0];
            p_q[0][l]   = '0;
        end
        p_len[0]  = i_len;
        p_side[0] = i_side;
        for (int s = 1; s < DIV_STAGES; s++) begin
            p_len[s]  = r_len[s-1];
            p_rem[s]  = r_rem[s-1];
            p_lo[s]   = r_lo[s-1];
            p_q[s]    = r_q[s-1];
            p_side[s] = r_side[s-1];
        end
    end

    always_comb begin
        logic [DR_W-1:0] rem;
        logic [Q_W-1:0]  lo;
        logic [Q_W-1:0]  q;
        logic [DR_W:0]   sh;
        for (int s = 0; s < DIV_STAGES; s++) begin
            for (int l = 0; l < 3; l++) begin
                rem = p_rem[s][l];
                lo  = p_lo[s][l];
                q   = p_q[s][l];
                for (int k = 0; k < DIV_STEPS; k++) begin
                    sh = {rem, lo[Q_W-1]};
                    lo = {lo[Q_W-2:0], 1'b0};
                    if (sh >= {1'b0, p_len[s]}) begin
                        rem = DR_W'(sh - {1'b0, p_len[s]});
                        q   = {q[Q_W-2:0], 1'b1};
                    end else begin
                        rem = DR_W'(sh);
                        q   = {q[Q_W-2:0], 1'b0};
                    end
                end
                n_rem[s][l] = rem;
                n_lo[s][l]  = lo;
                n_q[s][l]   = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_len[s]  <= p_len[s];
                r_rem[s]  <= n_rem[s];
                r_lo[s]   <= n_lo[s];
                r_q[s]    <= n_q[s];
                r_side[s] <= p_side[s];
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_quot  = r_q[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

[rtl/ray_refraction_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_refraction_unit
// Vector Snell refraction in fixed point: normalize, dot, discriminant,
// square root, refracted direction with saturation.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                   handshake
//  i_ray     in    dir_x/y/z, norm_x/y/z, eta_ratio          valid/ready
//  o_ray     out   out_x/y/z, refracts                       valid/ready
//
//  One ray per cycle while the pipeline advances. Rays pass the two square root
//  pipelines (15 stages each) and the 5-stage normalizing divider.
//  Synchronous active-low reset clears the valid bits only.
//  The whole pipeline advances when the output register is empty or being
//  taken; otherwise every stage holds and i_ray.ready is low.
// ----------------------------------------------------------------------------
module ray_refraction_unit (
    input logic       i_clk,
    input logic       i_rst_n,
    rru_in_if.sink    i_ray,
    rru_out_if.source o_ray
);
    import rru_pkg::*;

    localparam logic signed [OM_W-1:0] OM_ONE   = OM_W'(1) << 28;
    localparam logic signed [PR_W-1:0] DISC_ONE = PR_W'(1) << 44;
    localparam logic signed [O_W-1:0]  OMAX     = O_W'((64'sd1 <<< (CW-1)) - 64'sd1);
    localparam logic signed [O_W-1:0]  OMIN     = -OMAX - O_W'(1);

    logic adv;

    // stage A: input capture
    logic          r_a_vld;
    t_vec          r_a_dv, r_a_nn, n_a_dv, n_a_nn;
    logic [EW-1:0] r_a_eta;

    // stage B: squares
    logic                 r_b_vld;
    logic [2:0][SS_W-1:0] r_b_sqr, n_b_sqr;
    t_vec                 r_b_dv, r_b_nn;
    logic [EW-1:0]        r_b_eta;

    // length square root and divider
    logic [SS_W-1:0]     s2;
    t_side_len           len_in_side, len_out_side;
    t_side               len_in_vec, len_out_vec, div_in_vec, div_out_vec;
    logic                len_vld;
    logic [SQ_OUT_W-1:0] len;
    t_side_div           div_in_side, div_out_side;
    logic [2:0][DW-1:0]  dmag;
    logic                div_vld;
    logic [2:0][Q_W-1:0] quot;

    // stage D: signed normalized components and dot products
    logic                  r_d_vld;
    t_vec                  r_d_nv, r_d_nn, n_d_nv;
    logic [2:0][PR1_W-1:0] r_d_pr, n_d_pr;
    logic [EW-1:0]         r_d_eta;
    logic                  r_d_zero;

    // stage E: rounded dot product
    logic                  r_e_vld;
    logic signed [D_W-1:0] r_e_d, n_e_d;
    t_vec                  r_e_nv, r_e_nn;
    logic [EW-1:0]         r_e_eta;
    logic                  r_e_zero;

    // stage F: d^2, eta^2, d*n
    logic                 r_f_vld;
    logic [DD_W-1:0]      r_f_dd, n_f_dd;
    logic [E2_W-1:0]      r_f_e2, n_f_e2;
    logic [2:0][DN_W-1:0] r_f_dn, n_f_dn;
    t_vec                 r_f_nv, r_f_nn;
    logic [EW-1:0]        r_f_eta;
    logic                 r_f_zero;

    // stage G: partial products of eta^2 * (1 - d^2), tangential terms
    logic                   r_g_vld;
    logic signed [PH_W-1:0] r_g_phi, n_g_phi;
    logic [PL_W-1:0]        r_g_plo, n_g_plo;
    logic [2:0][T_W-1:0]    r_g_t, n_g_t;
    t_vec                   r_g_nn;
    logic [EW-1:0]          r_g_eta;
    logic                   r_g_zero;

    // discriminant square root
    logic signed [PR_W-1:0] disc;
    logic                   disc_pos;
    t_side_sq               sq_in_side, sq_out_side;
    t_side                  sq_in_vec, sq_out_vec;
    logic                   sq_vld;
    logic [SQ_OUT_W-1:0]    sq;

    // stage I: final products
    logic                  r_i_vld;
    logic [2:0][M1_W-1:0]  r_i_m1, n_i_m1;
    logic [2:0][M2_W-1:0]  r_i_m2, n_i_m2;
    logic                  r_i_pos;

    // output register
    logic     r_out_vld;
    t_ray_out r_out, n_out;

    assign adv         = !r_out_vld || o_ray.ready;
    assign i_ray.ready = adv;
    assign o_ray.valid = r_out_vld;
    assign o_ray.data  = r_out;

    // ---------------- stage A ----------------
    always_comb begin
        n_a_dv[0] = clamp_comp(i_ray.data.dir_x);
        n_a_dv[1] = clamp_comp(i_ray.data.dir_y);
        n_a_dv[2] = clamp_comp(i_ray.data.dir_z);
        n_a_nn[0] = clamp_comp(i_ray.data.norm_x);
        n_a_nn[1] = clamp_comp(i_ray.data.norm_y);
        n_a_nn[2] = clamp_comp(i_ray.data.norm_z);
    end

    // ---------------- stage B ----------------
    always_comb begin
        logic [DW-1:0] m;
        for (int l = 0; l < 3; l++) begin
            m          = mag_comp(r_a_dv[l]);
            n_b_sqr[l] = m * m;
        end
    end

    // ---------------- length and divider ----------------
    always_comb begin
        s2 = r_b_sqr[0] + r_b_sqr[1] + r_b_sqr[2];
        len_in_side.zero = (s2 == '0);
        len_in_side.dv   = r_b_dv;
        len_in_side.nn   = r_b_nn;
        len_in_side.eta  = r_b_eta;
        len_in_vec = {{(SIDE_W-$bits(t_side_len)){1'b0}}, len_in_side};
    end

    rru_sqrt_pipe u_len_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_valid    (r_b_vld),
        .i_radicand ({s2, 28'd0}),
        .i_side     (len_in_vec),
        .o_valid    (len_vld),
        .o_root     (len),
        .o_side     (len_out_vec)
    );

    always_comb begin
        len_out_side = t_side_len'(len_out_vec[$bits(t_side_len)-1:0]);
        for (int l = 0; l < 3; l++) begin
            dmag[l]            = mag_comp(len_out_side.dv[l]);
            div_in_side.sgn[l] = len_out_side.dv[l][DW-1];
        end
        div_in_side.zero = len_out_side.zero;
        div_in_side.nn   = len_out_side.nn;
        div_in_side.eta  = len_out_side.eta;
        div_in_vec = {{(SIDE_W-$bits(t_side_div)){1'b0}}, div_in_side};
    end

    rru_div_pipe u_norm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (len_vld),
        .i_len   (len),
        .i_mag   (dmag),
        .i_side  (div_in_vec),
        .o_valid (div_vld),
        .o_quot  (quot),
        .o_side  (div_out_vec)
    );

    // ---------------- stage D ----------------
    always_comb begin
        logic signed [DW-1:0] qm;
        div_out_side = t_side_div'(div_out_vec[$bits(t_side_div)-1:0]);
        for (int l = 0; l < 3; l++) begin
            qm        = $signed({1'b0, quot[l]});
            n_d_nv[l] = div_out_side.sgn[l] ? -qm : qm;
            n_d_pr[l] = PR1_W'($signed(n_d_nv[l]) * $signed(div_out_side.nn[l]));
        end
    end

    // ---------------- stage E ----------------
    always_comb begin
        logic signed [DOT_W-1:0] dot;
        logic [DOT_W-1:0]        dmg;
        logic [D_W-1:0]          rm;
        dot = DOT_W'($signed(r_d_pr[0])) + DOT_W'($signed(r_d_pr[1]))
            + DOT_W'($signed(r_d_pr[2]));
        dmg = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
        rm  = D_W'((dmg + DOT_W'(1 << 13)) >> 14);
        n_e_d = dot[DOT_W-1] ? -$signed(rm) : $signed(rm);
    end

    // ---------------- stage F ----------------
    always_comb begin
        logic [2*EW-1:0] ee;
        n_f_dd = DD_W'(r_e_d * r_e_d);
        ee     = r_e_eta * r_e_eta;
        n_f_e2 = ee[2*EW-1:8];
        for (int l = 0; l < 3; l++) begin
            n_f_dn[l] = DN_W'(r_e_d * $signed(r_e_nn[l]));
        end
    end

    // ---------------- stage G ----------------
    always_comb begin
        logic signed [OM_W-1:0]  om;
        logic signed [OMH_W-1:0] om_hi;
        logic [OML_W-1:0]        om_lo;
        om      = OM_ONE - $signed({1'b0, r_f_dd});
        // split om so that each product stays narrow; om = om_hi * 2^OML_W + om_lo
        om_hi   = om[OM_W-1:OML_W];
        om_lo   = om[OML_W-1:0];
        n_g_plo = r_f_e2 * om_lo;
        n_g_phi = $signed({1'b0, r_f_e2}) * om_hi;
        for (int l = 0; l < 3; l++) begin
            n_g_t[l] = (T_W'($signed(r_f_nv[l])) <<< 14) - T_W'($signed(r_f_dn[l]));
        end
    end

    // ---------------- discriminant square root ----------------
    always_comb begin
        disc     = DISC_ONE - (PR_W'(r_g_phi) <<< OML_W) - $signed(PR_W'(r_g_plo));
        disc_pos = !r_g_zero && !disc[PR_W-1] && (disc != '0);
        sq_in_side.pos = disc_pos;
        sq_in_side.t   = r_g_t;
        sq_in_side.nn  = r_g_nn;
        sq_in_side.eta = r_g_eta;
        sq_in_vec = {{(SIDE_W-$bits(t_side_sq)){1'b0}}, sq_in_side};
    end

    rru_sqrt_pipe u_disc_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_valid    (r_g_vld),
        .i_radicand (disc_pos ? disc[SQ_IN_W-1:0] : '0),
        .i_side     (sq_in_vec),
        .o_valid    (sq_vld),
        .o_root     (sq),
        .o_side     (sq_out_vec)
    );

    // ---------------- stage I ----------------
    always_comb begin
        sq_out_side = t_side_sq'(sq_out_vec[$bits(t_side_sq)-1:0]);
        for (int l = 0; l < 3; l++) begin
            n_i_m1[l] = $signed({1'b0, sq_out_side.eta}) * $signed(sq_out_side.t[l]);
            n_i_m2[l] = $signed({1'b0, sq}) * $signed(sq_out_side.nn[l]);
        end
    end

    // ---------------- output stage ----------------
    always_comb begin
        logic signed [R_W-1:0] r;
        logic [R_W-1:0]        rmg;
        logic [O_W-1:0]        m;
        logic signed [O_W-1:0] o;
        logic signed [2:0][CW-1:0] res;
        for (int l = 0; l < 3; l++) begin
            r   = R_W'($signed(r_i_m1[l])) - (R_W'($signed(r_i_m2[l])) <<< 4);
            rmg = r[R_W-1] ? R_W'(-r) : R_W'(r);
            m   = O_W'((rmg + R_W'(1 << 25)) >> 26);
            o   = r[R_W-1] ? -$signed(m) : $signed(m);
            if (o > OMAX) begin
                o = OMAX;
            end else if (o < OMIN) begin
                o = OMIN;
            end
            res[l] = r_i_pos ? CW'(o) : '0;
        end
        n_out.out_x    = res[0];
        n_out.out_y    = res[1];
        n_out.out_z    = res[2];
        n_out.refracts = r_i_pos;
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_g_vld   <= 1'b0;
            r_i_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld   <= i_ray.valid;
            r_b_vld   <= r_a_vld;
            r_d_vld   <= div_vld;
            r_e_vld   <= r_d_vld;
            r_f_vld   <= r_e_vld;
            r_g_vld   <= r_f_vld;
            r_i_vld   <= sq_vld;
            r_out_vld <= r_i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_dv   <= n_a_dv;
            r_a_nn   <= n_a_nn;
            r_a_eta  <= i_ray.data.eta_ratio;

            r_b_sqr  <= n_b_sqr;
            r_b_dv   <= r_a_dv;
            r_b_nn   <= r_a_nn;
            r_b_eta  <= r_a_eta;

            r_d_nv   <= n_d_nv;
            r_d_pr   <= n_d_pr;
            r_d_nn   <= div_out_side.nn;
            r_d_eta  <= div_out_side.eta;
            r_d_zero <= div_out_side.zero;

            r_e_d    <= n_e_d;
            r_e_nv   <= r_d_nv;
            r_e_nn   <= r_d_nn;
            r_e_eta  <= r_d_eta;
            r_e_zero <= r_d_zero;

            r_f_dd   <= n_f_dd;
            r_f_e2   <= n_f_e2;
            r_f_dn   <= n_f_dn;
            r_f_nv   <= r_e_nv;
            r_f_nn   <= r_e_nn;
            r_f_eta  <= r_e_eta;
            r_f_zero <= r_e_zero;

            r_g_phi  <= n_g_phi;
            r_g_plo  <= n_g_plo;
            r_g_t    <= n_g_t;
            r_g_nn   <= r_f_nn;
            r_g_eta  <= r_f_eta;
            r_g_zero <= r_f_zero;

            r_i_m1   <= n_i_m1;
            r_i_m2   <= n_i_m2;
            r_i_pos  <= sq_out_side.pos;

            r_out    <= n_out;
        end
    end

endmodule

[sim/tb_ray_refraction_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ray_refraction_unit
// Self-checking bench for the ray refraction unit. A directed set of rays
// and about 800 random ones are driven with random gaps. Each result
// transfer is checked against a fixed-point refraction predictor, in order.
// The output side stalls at random, once for a long stretch.
// ----------------------------------------------------------------------------
module tb_ray_refraction_unit;
    import rru_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic failed;

    rru_in_if  ray_in ();
    rru_out_if ray_out ();

    ray_refraction_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (ray_in.sink),
        .o_ray   (ray_out.source)
    );

    t_ray_in  pending_rays[$];
    t_ray_out expected_dirs[$];
    bit       stim_done;
    int       hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint round_away(input longint v, input int s);
        longint unsigned m;
        m = ((v < 0 ? -v : v) + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic t_ray_out refract_ray(input t_ray_in r);
        t_ray_out        res;
        longint          dv[3];
        longint          nn[3];
        longint          nv[3];
        longint          acc;
        longint          d;
        longint          om;
        longint          disc;
        longint          sq;
        longint          o;
        longint unsigned s2;
        longint unsigned len;
        longint unsigned q;
        longint unsigned e2;
        res = '0;
        dv[0] = r.dir_x;  dv[1] = r.dir_y;  dv[2] = r.dir_z;
        nn[0] = r.norm_x; nn[1] = r.norm_y; nn[2] = r.norm_z;
        s2 = 0;
        for (int i = 0; i < 3; i++) s2 += dv[i] * dv[i];
        if (s2 == 0) return res;
        len = int_sqrt(s2 << 28);
        if (len == 0) return res;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            q     = (((dv[i] < 0 ? -dv[i] : dv[i]) << 28) + (len >> 1)) / len;
            nv[i] = dv[i] < 0 ? -longint'(q) : longint'(q);
            acc  += nv[i] * nn[i];
        end
        d    = round_away(acc, 14);
        om   = (64'sd1 << 28) - d * d;
        e2   = (longint'(r.eta_ratio) * longint'(r.eta_ratio)) >> 8;
        disc = (64'sd1 << 44) - longint'(e2) * om;
        if (disc <= 0) return res;
        sq = longint'(int_sqrt(disc));
        for (int i = 0; i < 3; i++) begin
            o = round_away(longint'(r.eta_ratio) * (nv[i] * 16384 - d * nn[i])
                           - sq * nn[i] * 16, 26);
            if (o > C16_MAX) o = C16_MAX;
            if (o < C16_MIN) o = C16_MIN;
            if (i == 0) res.out_x = o[15:0];
            if (i == 1) res.out_y = o[15:0];
            if (i == 2) res.out_z = o[15:0];
        end
        res.refracts = 1'b1;
        return res;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 4))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom());
        endcase
    endfunction

    // random ray; three in four normals are unit normals near a random axis, scaled Q2.14, with a little noise
    function automatic t_ray_in rand_ray();
        t_ray_in r;
        logic [15:0] c[3];
        int ax;
        r.dir_x = rand_comp();
        r.dir_y = rand_comp();
        r.dir_z = rand_comp();
        if ($urandom_range(0, 3) == 0) begin
            r.norm_x = rand_comp();
            r.norm_y = rand_comp();
            r.norm_z = rand_comp();
        end else begin
            ax = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
                c[i] = 16'($urandom_range(0, 4000)) - 16'd2000;
            c[ax] = $urandom_range(0, 1) ? 16'd16384 : -16'sd16384;
            r.norm_x = c[0];
            r.norm_y = c[1];
            r.norm_z = c[2];
        end
        case ($urandom_range(0, 3))
            0: r.eta_ratio = 16'($urandom());
            1: r.eta_ratio = 16'($urandom_range(2048, 8192));
            default: r.eta_ratio = 16'($urandom_range(3000, 6000));
        endcase
        return r;
    endfunction

    function automatic t_ray_in mk_ray(input int dx, dy, dz, nx, ny, nz, eta);
        t_ray_in r;
        r.dir_x = 16'(dx);  r.dir_y = 16'(dy);  r.dir_z = 16'(dz);
        r.norm_x = 16'(nx); r.norm_y = 16'(ny); r.norm_z = 16'(nz);
        r.eta_ratio = 16'(eta);
        return r;
    endfunction

    initial begin
        stim_done = 1'b0;
        // zero direction, straight through, grazing total reflection,
        // extremes, non-unit normal, index zero and maximum
        pending_rays.push_back(mk_ray(0, 0, 0, 0, 0, 16384, 4096));
        pending_rays.push_back(mk_ray(0, 0, -100, 0, 0, 16384, 4096));
        pending_rays.push_back(mk_ray(0, 0, -1, 0, 0, 16384, 5461));
        pending_rays.push_back(mk_ray(1000, 0, -10, 0, 0, 16384, 6144));
        pending_rays.push_back(mk_ray(1000, 0, -1000, 0, 0, 16384, 3072));
        pending_rays.push_back(mk_ray(1000, 0, -1000, 0, 0, 16384, 6144));
        pending_rays.push_back(mk_ray(32767, 32767, 32767, 16384, 0, 0, 4096));
        pending_rays.push_back(mk_ray(-32768, -32768, -32768, 0, 16384, 0, 4096));
        pending_rays.push_back(mk_ray(-32768, 32767, 0, 32767, 32767, 32767, 65535));
        pending_rays.push_back(mk_ray(1, -1, 1, -32768, -32768, -32768, 65535));
        pending_rays.push_back(mk_ray(300, 200, -100, 0, 0, -16384, 0));
        pending_rays.push_back(mk_ray(300, 200, -100, 32767, -32768, 0, 65535));
        pending_rays.push_back(mk_ray(0, 0, 5, 0, 0, 0, 4096));
        pending_rays.push_back(mk_ray(0, 7, 0, 0, -16384, 0, 2731));
        pending_rays.push_back(mk_ray(-1, 0, 0, 16384, 0, 0, 65535));
        for (int i = 0; i < 800; i++) pending_rays.push_back(rand_ray());
        stim_done = 1'b1;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    // driver
    int       in_gap;
    t_ray_in  cur_ray;
    bit       in_taken;
    initial begin
        ray_in.valid = 1'b0;
        ray_in.data  = '0;
        in_gap       = 0;
        in_taken     = 1'b0;
    end

    // record the input transfer at the edge where it happens
    always @(posedge i_clk) begin
        in_taken <= ray_in.valid && ray_in.ready;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (ray_in.valid && in_taken) begin
                expected_dirs.push_back(refract_ray(cur_ray));
                in_gap = gap_len();
                if (in_gap == 0 && pending_rays.size() > 0) begin
                    cur_ray      = pending_rays.pop_front();
                    ray_in.data <= cur_ray;
                end else begin
                    ray_in.valid <= 1'b0;
                end
            end else if (!ray_in.valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pending_rays.size() > 0) begin
                    cur_ray       = pending_rays.pop_front();
                    ray_in.data  <= cur_ray;
                    ray_in.valid <= 1'b1;
                end
            end
        end
    end

    // receiver stall pattern; one long hold-off early in the random part
    int  out_gap;
    int  results_seen;
    bit  long_hold_done;
    initial begin
        ray_out.ready  = 1'b0;
        out_gap        = 0;
        long_hold_done = 1'b0;
        hold_cycles    = 0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            ray_out.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            ray_out.ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 40) begin
            long_hold_done = 1'b1;
            hold_cycles    = 200;
            ray_out.ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            ray_out.ready <= 1'b0;
        end else begin
            out_gap = gap_len();
            ray_out.ready <= (out_gap == 0);
        end
    end

    // monitor
    t_ray_out want;
    initial begin
        failed       = 1'b0;
        results_seen = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ray_out.valid && ray_out.ready) begin
            results_seen++;
            if (expected_dirs.size() == 0) begin
                $error("result transfer with no ray outstanding");
                failed = 1'b1;
            end else begin
                want = expected_dirs.pop_front();
                if (ray_out.data.out_x !== want.out_x) begin
                    $error("out_x: expected %0d got %0d", want.out_x, ray_out.data.out_x);
                    failed = 1'b1;
                end
                if (ray_out.data.out_y !== want.out_y) begin
                    $error("out_y: expected %0d got %0d", want.out_y, ray_out.data.out_y);
                    failed = 1'b1;
                end
                if (ray_out.data.out_z !== want.out_z) begin
                    $error("out_z: expected %0d got %0d", want.out_z, ray_out.data.out_z);
                    failed = 1'b1;
                end
                if (ray_out.data.refracts !== want.refracts) begin
                    $error("refracts: expected %0d got %0d", want.refracts,
                           ray_out.data.refracts);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        wait (stim_done && pending_rays.size() == 0 && !ray_in.valid);
        wait (expected_dirs.size() == 0);
        repeat (100) @(posedge i_clk);
        if (expected_dirs.size() != 0) failed = 1'b1;
        if (!failed) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
